FILE: src/wfwa_pkg.sv
// wfwa_pkg: widths, fixed-point constants and sequencer states of the wrapped
// fraction weighted average block
// no dependencies
package wfwa_pkg;

    localparam int FRAC_BITS = 16;
    localparam int PITCH_W   = 24;
    localparam int SF_W      = 18;
    localparam int WEIGHT_W  = 17;
    localparam int AVG_W     = 18;
    localparam int SPREAD_W  = 16;
    localparam int BEST_W    = 32;
    localparam int DIFF_W    = SF_W + 2;
    localparam int MUL_A_W   = 34;
    localparam int MUL_B_W   = 25;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int WBIT_W    = $clog2(FRAC_BITS);

    localparam logic [WEIGHT_W-1:0]      ONE_W   = WEIGHT_W'(1) << FRAC_BITS;
    localparam logic [PITCH_W:0]         ONE_D   = (PITCH_W + 1)'(1) << FRAC_BITS;
    localparam logic signed [SF_W-1:0]   ONE_SF  = SF_W'(1) << FRAC_BITS;
    localparam logic signed [SF_W-1:0]   HALF_SF = SF_W'(1) << (FRAC_BITS - 1);
    localparam logic [MUL_P_W-1:0]       WEIGHT_LIMIT = MUL_P_W'(1) << (3 * FRAC_BITS);
    localparam logic [SPREAD_W-1:0]      SPREAD_MAX = '1;

    typedef enum logic [4:0] {
        ST_COLLECT,
        ST_CTR_RD,
        ST_CTR_LD,
        ST_SU_RD,
        ST_SU_LD,
        ST_WT_SQ,
        ST_WT_MUL,
        ST_WT_CMP,
        ST_SU_WR,
        ST_PASS_START,
        ST_A_RD,
        ST_A_MUL,
        ST_A_ACC,
        ST_AVG_DIV,
        ST_AVG_WAIT,
        ST_B_RD,
        ST_B_SQ,
        ST_B_MUL,
        ST_B_ACC,
        ST_SPR_DIV,
        ST_SPR_WAIT,
        ST_PASS_END,
        ST_DONE
    } state_t;

endpackage

FILE: src/wfwa_mul.sv
// wfwa_mul: shared signed multiplier with a registered product
// depends on wfwa_pkg
module wfwa_mul (
    input  logic                                  aclk,
    input  logic signed [wfwa_pkg::MUL_A_W-1:0]   a,
    input  logic signed [wfwa_pkg::MUL_B_W-1:0]   b,
    output logic signed [wfwa_pkg::MUL_P_W-1:0]   p
);

    logic signed [wfwa_pkg::MUL_P_W-1:0] p_reg;

    always_ff @(posedge aclk) begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

FILE: src/wfwa_div.sv
// wfwa_div: unsigned restoring divider, one quotient bit per cycle
// standalone, no package use
module wfwa_div #(
    parameter int DW = 42,
    parameter int VW = 23
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          busy,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] quo_reg;
    logic [VW-1:0] rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [VW:0]   shifted;
    logic [VW:0]   trial;

    assign shifted = {rem_reg, quo_reg[DW-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(DW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            // no borrow means the divisor fits
            if (!trial[VW]) begin
                rem_reg <= trial[VW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[VW-1:0];
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: src/wrapped_fraction_weighted_average_top.sv
// wrapped_fraction_weighted_average_top: set collection, sequencer, element stores
// depends on wfwa_pkg, wfwa_mul, wfwa_div
//
//   port group  | dir | handshake          | payload
//   s_*         | in  | s_valid / s_ready  | s_pitch, s_center_mark, s_last
//   m_*         | out | m_valid / m_ready  | m_average, m_spread, m_single_element
//
// collecting: one element per cycle, s_ready high until the element marked last
// after last: per element setup, with a weight bit search on the multiplier where the distance exceeds one
// each pass: average steps, a DW-bit division, spread steps, a second division when wsum exceeds one;
// DW = 35 + clog2(MAX_ELEMENTS + 1); up to n + 1 passes; a single element set skips setup and passes
// reset (aresetn low, synchronous) empties the set; stores need no clearing
// the next set is collected while a result waits on m_ready
module wrapped_fraction_weighted_average_top #(
    parameter int MAX_ELEMENTS = 64
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [wfwa_pkg::PITCH_W-1:0]          s_pitch,
    input  logic                                  s_center_mark,
    input  logic                                  s_last,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [wfwa_pkg::AVG_W-1:0]     m_average,
    output logic [wfwa_pkg::SPREAD_W-1:0]         m_spread,
    output logic                                  m_single_element
);

    localparam int IDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
    localparam int WSUM_W = wfwa_pkg::FRAC_BITS + CNT_W;
    localparam int NUM_W  = 34 + CNT_W;
    localparam int ACC_W  = 35 + CNT_W;
    localparam int DW     = ACC_W;
    localparam int SF_W   = wfwa_pkg::SF_W;
    localparam int DIFF_W = wfwa_pkg::DIFF_W;
    localparam logic signed [DIFF_W-1:0] ONE_DF  = DIFF_W'(1) << wfwa_pkg::FRAC_BITS;
    localparam logic signed [DIFF_W-1:0] HALF_DF = DIFF_W'(1) << (wfwa_pkg::FRAC_BITS - 1);

    wfwa_pkg::state_t state_reg, state_next;

    // collection
    logic [CNT_W-1:0] count_reg;
    logic [IDX_W-1:0] center_reg;
    logic [CNT_W-1:0] n_reg;
    logic [IDX_W-1:0] c_reg;

    // datapath
    logic [IDX_W-1:0]                   idx_reg;
    logic [wfwa_pkg::PITCH_W-1:0]       cpitch_reg;
    logic [wfwa_pkg::PITCH_W-1:0]       d_reg;
    logic [wfwa_pkg::WEIGHT_W-1:0]      w_reg;
    logic [wfwa_pkg::WBIT_W-1:0]        bit_reg;
    logic [WSUM_W-1:0]                  wsum_reg;
    logic signed [NUM_W-1:0]            num_reg;
    logic [ACC_W-1:0]                   acc_reg;
    logic signed [wfwa_pkg::AVG_W-1:0]  avg_reg;
    logic signed [wfwa_pkg::AVG_W-1:0]  best_avg_reg;
    logic [wfwa_pkg::BEST_W-1:0]        best_spread_reg;
    logic [wfwa_pkg::BEST_W-1:0]        cur_reg;
    logic signed [SF_W-1:0]             curmin_reg;
    logic signed [SF_W-1:0]             mi_reg;
    logic                               first_reg;
    logic                               single_reg;

    // result register
    logic                               m_valid_reg;
    logic signed [wfwa_pkg::AVG_W-1:0]  m_average_reg;
    logic [wfwa_pkg::SPREAD_W-1:0]      m_spread_reg;
    logic                               m_single_reg;

    // stores
    logic [wfwa_pkg::PITCH_W-1:0]  pitch_mem [MAX_ELEMENTS];
    logic signed [SF_W-1:0]        sf_mem [MAX_ELEMENTS];
    logic [wfwa_pkg::WEIGHT_W-1:0] w_mem [MAX_ELEMENTS];
    logic [wfwa_pkg::PITCH_W-1:0]  pitch_rd_reg;
    logic signed [SF_W-1:0]        sf_rd_reg;
    logic [wfwa_pkg::WEIGHT_W-1:0] w_rd_reg;

    // control
    logic                                  accept;
    logic                                  room;
    logic                                  pitch_we;
    logic [IDX_W-1:0]                      pitch_raddr;
    logic                                  sf_we;
    logic signed [SF_W-1:0]                sf_wdata;
    logic                                  w_we;
    logic                                  div_start;
    logic [DW-1:0]                         div_dividend;
    logic [WSUM_W-1:0]                     div_divisor;
    logic                                  div_busy;
    logic                                  div_done;
    logic [DW-1:0]                         div_quotient;
    logic signed [wfwa_pkg::MUL_A_W-1:0]   mul_a;
    logic signed [wfwa_pkg::MUL_B_W-1:0]   mul_b;
    logic signed [wfwa_pkg::MUL_P_W-1:0]   mul_p;
    logic                                  out_free;

    // combinational helpers
    logic                               last_elem;
    logic [wfwa_pkg::FRAC_BITS-1:0]     frac;
    logic signed [SF_W-1:0]             sf_shift;
    logic [wfwa_pkg::PITCH_W-1:0]       d_now;
    logic [wfwa_pkg::WEIGHT_W-1:0]      t_now;
    logic                               raise;
    logic signed [SF_W-1:0]             fnew;
    logic signed [DIFF_W-1:0]           diff_raw;
    logic signed [DIFF_W-1:0]           diff_wrap;
    logic [DIFF_W-1:0]                  ad;
    logic [NUM_W-1:0]                   num_mag;
    logic [wfwa_pkg::AVG_W-1:0]         q_avg;
    logic                               wsum_big;

    assign accept    = s_valid && s_ready;
    assign room      = (count_reg < CNT_W'(MAX_ELEMENTS));
    assign out_free  = !m_valid_reg || m_ready;
    assign last_elem = ((CNT_W'(idx_reg) + CNT_W'(1)) == n_reg);
    assign frac      = pitch_rd_reg[wfwa_pkg::FRAC_BITS-1:0];
    assign sf_shift  = SF_W'(frac) - (frac[wfwa_pkg::FRAC_BITS-1] ? wfwa_pkg::ONE_SF : '0);
    assign d_now     = (pitch_rd_reg > cpitch_reg) ? (pitch_rd_reg - cpitch_reg)
                                                   : (cpitch_reg - pitch_rd_reg);
    assign t_now     = w_reg | (wfwa_pkg::WEIGHT_W'(1) << bit_reg);
    assign raise     = !first_reg && (sf_rd_reg <= curmin_reg);
    assign fnew      = raise ? (sf_rd_reg + wfwa_pkg::ONE_SF) : sf_rd_reg;
    assign diff_raw  = DIFF_W'(sf_rd_reg) - DIFF_W'(avg_reg);
    assign num_mag   = num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
    assign q_avg     = div_quotient[wfwa_pkg::AVG_W-1:0];
    assign wsum_big  = (wsum_reg > WSUM_W'(wfwa_pkg::ONE_W));

    // fold the difference into the closed half-unit interval around zero (sign may flip); ad is its magnitude
    always_comb begin
        if (diff_raw > HALF_DF) begin
            diff_wrap = ONE_DF - diff_raw;
        end else if (diff_raw < -HALF_DF) begin
            diff_wrap = -ONE_DF - diff_raw;
        end else begin
            diff_wrap = diff_raw;
        end
        ad = diff_wrap[DIFF_W-1] ? DIFF_W'(-diff_wrap) : DIFF_W'(diff_wrap);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wfwa_pkg::ST_COLLECT: begin
                if (accept && s_last) state_next = wfwa_pkg::ST_CTR_RD;
            end
            wfwa_pkg::ST_CTR_RD:  state_next = wfwa_pkg::ST_CTR_LD;
            wfwa_pkg::ST_CTR_LD: begin
                state_next = (n_reg == CNT_W'(1)) ? wfwa_pkg::ST_DONE : wfwa_pkg::ST_SU_RD;
            end
            wfwa_pkg::ST_SU_RD:   state_next = wfwa_pkg::ST_SU_LD;
            wfwa_pkg::ST_SU_LD: begin
                state_next = ({1'b0, d_now} <= wfwa_pkg::ONE_D) ? wfwa_pkg::ST_SU_WR
                                                                : wfwa_pkg::ST_WT_SQ;
            end
            wfwa_pkg::ST_WT_SQ:   state_next = wfwa_pkg::ST_WT_MUL;
            wfwa_pkg::ST_WT_MUL:  state_next = wfwa_pkg::ST_WT_CMP;
            wfwa_pkg::ST_WT_CMP: begin
                state_next = (bit_reg == '0) ? wfwa_pkg::ST_SU_WR : wfwa_pkg::ST_WT_SQ;
            end
            wfwa_pkg::ST_SU_WR: begin
                state_next = last_elem ? wfwa_pkg::ST_PASS_START : wfwa_pkg::ST_SU_RD;
            end
            wfwa_pkg::ST_PASS_START: state_next = wfwa_pkg::ST_A_RD;
            wfwa_pkg::ST_A_RD:    state_next = wfwa_pkg::ST_A_MUL;
            wfwa_pkg::ST_A_MUL:   state_next = wfwa_pkg::ST_A_ACC;
            wfwa_pkg::ST_A_ACC: begin
                state_next = last_elem ? wfwa_pkg::ST_AVG_DIV : wfwa_pkg::ST_A_RD;
            end
            wfwa_pkg::ST_AVG_DIV: state_next = wfwa_pkg::ST_AVG_WAIT;
            wfwa_pkg::ST_AVG_WAIT: begin
                if (div_done) state_next = wfwa_pkg::ST_B_RD;
            end
            wfwa_pkg::ST_B_RD:    state_next = wfwa_pkg::ST_B_SQ;
            wfwa_pkg::ST_B_SQ:    state_next = wfwa_pkg::ST_B_MUL;
            wfwa_pkg::ST_B_MUL:   state_next = wfwa_pkg::ST_B_ACC;
            wfwa_pkg::ST_B_ACC: begin
                state_next = last_elem ? wfwa_pkg::ST_SPR_DIV : wfwa_pkg::ST_B_RD;
            end
            wfwa_pkg::ST_SPR_DIV: begin
                state_next = wsum_big ? wfwa_pkg::ST_SPR_WAIT : wfwa_pkg::ST_PASS_END;
            end
            wfwa_pkg::ST_SPR_WAIT: begin
                if (div_done) state_next = wfwa_pkg::ST_PASS_END;
            end
            wfwa_pkg::ST_PASS_END: begin
                state_next = (mi_reg < wfwa_pkg::HALF_SF) ? wfwa_pkg::ST_PASS_START
                                                          : wfwa_pkg::ST_DONE;
            end
            wfwa_pkg::ST_DONE: begin
                if (out_free) state_next = wfwa_pkg::ST_COLLECT;
            end
            default: state_next = wfwa_pkg::ST_COLLECT;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready      = 1'b0;
        pitch_we     = 1'b0;
        pitch_raddr  = idx_reg;
        sf_we        = 1'b0;
        sf_wdata     = sf_shift;
        w_we         = 1'b0;
        div_start    = 1'b0;
        div_dividend = DW'(acc_reg);
        div_divisor  = wsum_reg - WSUM_W'(wfwa_pkg::ONE_W);
        mul_a        = wfwa_pkg::MUL_A_W'(t_now);
        mul_b        = wfwa_pkg::MUL_B_W'(t_now);
        case (state_reg)
            wfwa_pkg::ST_COLLECT: begin
                s_ready  = 1'b1;
                pitch_we = accept && room;
            end
            wfwa_pkg::ST_CTR_RD: pitch_raddr = c_reg;
            wfwa_pkg::ST_SU_LD:  sf_we = 1'b1;
            wfwa_pkg::ST_WT_MUL: begin
                mul_a = mul_p[wfwa_pkg::MUL_A_W-1:0];
                mul_b = wfwa_pkg::MUL_B_W'(d_reg);
            end
            wfwa_pkg::ST_SU_WR:  w_we = 1'b1;
            wfwa_pkg::ST_A_MUL: begin
                sf_we    = raise;
                sf_wdata = fnew;
                mul_a    = wfwa_pkg::MUL_A_W'(fnew);
                mul_b    = wfwa_pkg::MUL_B_W'(w_rd_reg);
            end
            wfwa_pkg::ST_AVG_DIV: begin
                div_start    = 1'b1;
                div_dividend = DW'(num_mag);
                div_divisor  = wsum_reg;
            end
            wfwa_pkg::ST_B_SQ: begin
                mul_a = wfwa_pkg::MUL_A_W'(ad);
                mul_b = wfwa_pkg::MUL_B_W'(ad);
            end
            wfwa_pkg::ST_B_MUL: begin
                mul_a = mul_p[wfwa_pkg::FRAC_BITS +: wfwa_pkg::MUL_A_W];
                mul_b = wfwa_pkg::MUL_B_W'(w_rd_reg);
            end
            wfwa_pkg::ST_SPR_DIV: div_start = wsum_big;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wfwa_pkg::ST_COLLECT;
            count_reg   <= '0;
            center_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                if (room) begin
                    count_reg <= count_reg + CNT_W'(1);
                    if (s_center_mark) center_reg <= count_reg[IDX_W-1:0];
                end
                if (s_last) begin
                    count_reg  <= '0;
                    center_reg <= '0;
                end
            end
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (state_reg == wfwa_pkg::ST_DONE && out_free) m_valid_reg <= 1'b1;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            wfwa_pkg::ST_COLLECT: begin
                if (accept && s_last) begin
                    n_reg <= count_reg + (room ? CNT_W'(1) : '0);
                    c_reg <= (room && s_center_mark) ? count_reg[IDX_W-1:0] : center_reg;
                end
            end
            wfwa_pkg::ST_CTR_LD: begin
                cpitch_reg      <= pitch_rd_reg;
                best_avg_reg    <= wfwa_pkg::AVG_W'(frac);
                best_spread_reg <= '1;
                single_reg      <= (n_reg == CNT_W'(1));
                idx_reg         <= '0;
                wsum_reg        <= '0;
            end
            wfwa_pkg::ST_SU_LD: begin
                d_reg   <= d_now;
                bit_reg <= wfwa_pkg::WBIT_W'(wfwa_pkg::FRAC_BITS - 1);
                w_reg   <= ({1'b0, d_now} <= wfwa_pkg::ONE_D) ? wfwa_pkg::ONE_W : '0;
            end
            wfwa_pkg::ST_WT_CMP: begin
                if ($unsigned(mul_p) <= wfwa_pkg::WEIGHT_LIMIT) w_reg <= t_now;
                bit_reg <= bit_reg - wfwa_pkg::WBIT_W'(1);
            end
            wfwa_pkg::ST_SU_WR: begin
                wsum_reg   <= wsum_reg + WSUM_W'(w_reg);
                idx_reg    <= idx_reg + IDX_W'(1);
                first_reg  <= 1'b1;
                curmin_reg <= {1'b1, {(SF_W-1){1'b0}}};
            end
            wfwa_pkg::ST_PASS_START: begin
                idx_reg <= '0;
                num_reg <= '0;
                acc_reg <= '0;
            end
            wfwa_pkg::ST_A_MUL: begin
                if (idx_reg == '0 || fnew < mi_reg) mi_reg <= fnew;
            end
            wfwa_pkg::ST_A_ACC: begin
                num_reg <= num_reg + NUM_W'(mul_p);
                idx_reg <= last_elem ? '0 : idx_reg + IDX_W'(1);
            end
            wfwa_pkg::ST_AVG_WAIT: begin
                if (div_done) avg_reg <= num_reg[NUM_W-1] ? -q_avg : q_avg;
            end
            wfwa_pkg::ST_B_ACC: begin
                acc_reg <= acc_reg + ACC_W'($unsigned(mul_p));
                idx_reg <= idx_reg + IDX_W'(1);
            end
            wfwa_pkg::ST_SPR_DIV: begin
                if (!wsum_big) cur_reg <= '1;
            end
            wfwa_pkg::ST_SPR_WAIT: begin
                if (div_done) begin
                    cur_reg <= (|div_quotient[DW-1:wfwa_pkg::BEST_W]) ? '1
                               : div_quotient[wfwa_pkg::BEST_W-1:0];
                end
            end
            wfwa_pkg::ST_PASS_END: begin
                if (cur_reg < best_spread_reg) begin
                    best_spread_reg <= cur_reg;
                    best_avg_reg    <= avg_reg;
                end
                curmin_reg <= mi_reg;
                first_reg  <= 1'b0;
            end
            wfwa_pkg::ST_DONE: begin
                if (out_free) begin
                    m_average_reg <= best_avg_reg;
                    m_spread_reg  <= (|best_spread_reg[wfwa_pkg::BEST_W-1:wfwa_pkg::SPREAD_W])
                                     ? wfwa_pkg::SPREAD_MAX
                                     : best_spread_reg[wfwa_pkg::SPREAD_W-1:0];
                    m_single_reg  <= single_reg;
                end
            end
            default: ;
        endcase
    end

    // element stores
    always_ff @(posedge aclk) begin
        if (pitch_we) pitch_mem[count_reg[IDX_W-1:0]] <= s_pitch;
        pitch_rd_reg <= pitch_mem[pitch_raddr];
    end

    always_ff @(posedge aclk) begin
        if (sf_we) sf_mem[idx_reg] <= sf_wdata;
        sf_rd_reg <= sf_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (w_we) w_mem[idx_reg] <= w_reg;
        w_rd_reg <= w_mem[idx_reg];
    end

    wfwa_mul u_mul (
        .aclk (aclk),
        .a    (mul_a),
        .b    (mul_b),
        .p    (mul_p)
    );

    wfwa_div #(
        .DW (DW),
        .VW (WSUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign m_valid          = m_valid_reg;
    assign m_average        = m_average_reg;
    assign m_spread         = m_spread_reg;
    assign m_single_element = m_single_reg;

    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ELEMENTS))
        else $error("element count beyond capacity");

    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        w_we |-> w_reg <= wfwa_pkg::ONE_W)
        else $error("weight above one");

    a_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wfwa_pkg::ST_DONE && out_free) |=> m_valid_reg)
        else $error("result not presented after completion");

    a_no_input_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != wfwa_pkg::ST_COLLECT) |-> !pitch_we)
        else $error("store written while computing");

endmodule
